// File: design/hmac_challenge_verifier_defines.svh
// Assertion helpers used by the checker file.
`ifndef HMAC_CHALLENGE_VERIFIER_DEFINES_SVH
`define HMAC_CHALLENGE_VERIFIER_DEFINES_SVH

// clocked check, off while reset is asserted
`define HCV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hcv check failed");

// clocked check that also holds during reset
`define HCV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hcv reset check failed");

`endif

// File: design/hcv_pkg.sv
package hcv_pkg;

  localparam int RESPONSE_BYTES = 32;

  localparam logic OP_CHALLENGE = 1'b0;
  localparam logic OP_RESPONSE  = 1'b1;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_START = 8'h80;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED  = 2'd0,
    VERDICT_REPLAY    = 2'd1,
    VERDICT_MAC_FAIL  = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_e;

  typedef enum logic {
    JOB_VERIFY    = 1'b0,
    JOB_MALFORMED = 1'b1
  } job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_MAC,
    ST_EMIT
  } back_state_e;

  // back end requests to the byte buffers in the front end
  typedef struct packed {
    logic rotate_chal;
    logic release_lock;
  } buf_ctrl_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    rotr32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    case (t)
      6'd0:  sha_k = 32'h428a2f98;  6'd1:  sha_k = 32'h71374491;
      6'd2:  sha_k = 32'hb5c0fbcf;  6'd3:  sha_k = 32'he9b5dba5;
      6'd4:  sha_k = 32'h3956c25b;  6'd5:  sha_k = 32'h59f111f1;
      6'd6:  sha_k = 32'h923f82a4;  6'd7:  sha_k = 32'hab1c5ed5;
      6'd8:  sha_k = 32'hd807aa98;  6'd9:  sha_k = 32'h12835b01;
      6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
      6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
      6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
      6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
      6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
      6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
      6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
      6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
      6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
      6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
      6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
      6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
      6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
      6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
      6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
      6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
      6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
      6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
      6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
      6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
      6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
      6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
      6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
      6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
      6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
      6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
      6'd62: sha_k = 32'hbef9a3f7;  6'd63: sha_k = 32'hc67178f2;
      default: sha_k = 32'h0;
    endcase
  endfunction

endpackage

// File: design/hcv_if.sv
interface hcv_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output operation, output data_byte, output last_byte,
                 input ready);
  modport sink(input valid, input operation, input data_byte, input last_byte,
               output ready);
endinterface

interface hcv_out_if import hcv_pkg::*;;
  logic        valid;
  logic        ready;
  verdict_e    verdict;
  logic [31:0] attempts_count;
  logic [31:0] accepted_count;
  logic [31:0] replay_count;
  logic [31:0] mac_fail_count;

  modport source(output valid, output verdict, output attempts_count,
                 output accepted_count, output replay_count, output mac_fail_count,
                 input ready);
  modport sink(input valid, input verdict, input attempts_count,
               input accepted_count, input replay_count, input mac_fail_count,
               output ready);
endinterface

// File: design/hmac_challenge_verifier.sv
// HMAC-SHA256 challenge-response verifier.
// in_i carries one byte per transaction: CHALLENGE_BYTES challenge bytes
// (operation 0), then 32 response bytes (operation 1), last_byte set on the
// final one. out_o carries one verdict per finished or malformed sequence,
// together with the four wrapping tally counters after that verdict.
// The key is loaded through cfg_we_i/cfg_idx_i/cfg_data_i, four 64-bit words.
// Bytes are taken one per cycle while in_i.ready is high. After the final
// response byte the input stalls until the verdict leaves the back end. A
// full check runs each SHA-256 block through the single shared round unit
// (load, rounds, add): four blocks for challenges up to 55 bytes, five for
// 56 to 119. Replays skip the hash; malformed verdicts go straight from
// the job queue to the output.
// Reset clears counters, fill counts, the stored-challenge flag and the
// queue; the key resets to zero. A stalled result is held in the output
// register; the back end then waits and the input stalls once the job
// queue fills.
module hmac_challenge_verifier import hcv_pkg::*; #(
  parameter int CHALLENGE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcv_in_if.sink      in_i,
  hcv_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q;
  logic        push, full, pop, job_valid;
  job_e        push_kind, job_kind;
  buf_ctrl_t   ctrl;
  logic [CHALLENGE_BYTES*8-1:0] chal;
  logic [RESPONSE_BYTES*8-1:0]  resp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
      key3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_WORD_0: key0_q <= cfg_data_i;
        CFG_KEY_WORD_1: key1_q <= cfg_data_i;
        CFG_KEY_WORD_2: key2_q <= cfg_data_i;
        CFG_KEY_WORD_3: key3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hcv_front #(.CHALLENGE_BYTES(CHALLENGE_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_kind_o (push_kind),
    .full_i      (full),
    .ctrl_i      (ctrl),
    .chal_o      (chal),
    .resp_o      (resp)
  );

  hcv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_kind_i (push_kind),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .kind_o      (job_kind)
  );

  hcv_back #(.CHALLENGE_BYTES(CHALLENGE_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_kind_i  (job_kind),
    .pop_o       (pop),
    .key_i       ({key0_q, key1_q, key2_q, key3_q}),
    .chal_i      (chal),
    .resp_i      (resp),
    .ctrl_o      (ctrl),
    .out_o       (out_o)
  );

endmodule

// File: design/hcv_queue.sv
module hcv_queue import hcv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_e push_kind_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_e kind_o
);

  job_e       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign kind_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_kind_i;
    end
  end

endmodule

// File: design/hcv_front.sv
module hcv_front import hcv_pkg::*; #(
  parameter int CHALLENGE_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hcv_in_if.sink                       in_i,
  output logic                         push_o,
  output job_e                         push_kind_o,
  input  logic                         full_i,
  input  buf_ctrl_t                    ctrl_i,
  output logic [CHALLENGE_BYTES*8-1:0] chal_o,
  output logic [RESPONSE_BYTES*8-1:0]  resp_o
);

  localparam int CW = CHALLENGE_BYTES * 8;
  localparam int FW = $clog2(CHALLENGE_BYTES + 1);
  localparam int RFW = $clog2(RESPONSE_BYTES + 1);

  logic [FW-1:0]  chal_fill_q, chal_fill_d;
  logic [RFW-1:0] resp_fill_q, resp_fill_d;
  logic           lock_q, lock_d;
  logic [CW-1:0]  chal_q, chal_d;
  logic [RESPONSE_BYTES*8-1:0] resp_q, resp_d;
  logic [CW+7:0]  chal_shift, chal_rot;
  logic           accept;

  assign in_i.ready = !lock_q && !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign chal_shift = {chal_q, in_i.data_byte};
  assign chal_rot   = {chal_q, chal_q[CW-1 -: 8]};
  assign chal_o     = chal_q;
  assign resp_o     = resp_q;

  always_comb begin
    chal_fill_d = chal_fill_q;
    resp_fill_d = resp_fill_q;
    lock_d      = lock_q;
    chal_d      = chal_q;
    resp_d      = resp_q;
    push_o      = 1'b0;
    push_kind_o = JOB_VERIFY;
    if (ctrl_i.rotate_chal) begin
      chal_d = chal_rot[CW-1:0];
    end
    if (ctrl_i.release_lock) begin
      lock_d = 1'b0;
    end
    if (accept) begin
      if (in_i.operation == OP_CHALLENGE) begin
        if (in_i.last_byte || resp_fill_q != '0 || chal_fill_q == FW'(CHALLENGE_BYTES)) begin
          push_o      = 1'b1;
          push_kind_o = JOB_MALFORMED;
        end else begin
          chal_d      = chal_shift[CW-1:0];
          chal_fill_d = chal_fill_q + 1'b1;
        end
      end else begin
        if (chal_fill_q != FW'(CHALLENGE_BYTES)
            || resp_fill_q == RFW'(RESPONSE_BYTES)) begin
          push_o      = 1'b1;
          push_kind_o = JOB_MALFORMED;
        end else begin
          resp_d      = {resp_q[RESPONSE_BYTES*8-9:0], in_i.data_byte};
          resp_fill_d = resp_fill_q + 1'b1;
          if (in_i.last_byte) begin
            push_o = 1'b1;
            if (resp_fill_q != RFW'(RESPONSE_BYTES - 1)) begin
              push_kind_o = JOB_MALFORMED;
            end else begin
              // buffers stay frozen until the back end is done with them
              lock_d = 1'b1;
            end
          end
        end
      end
      if (push_o) begin
        chal_fill_d = '0;
        resp_fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chal_fill_q <= '0;
      resp_fill_q <= '0;
      lock_q      <= 1'b0;
    end else begin
      chal_fill_q <= chal_fill_d;
      resp_fill_q <= resp_fill_d;
      lock_q      <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chal_q <= chal_d;
    resp_q <= resp_d;
  end

endmodule

// File: design/hcv_back.sv
module hcv_back import hcv_pkg::*; #(
  parameter int CHALLENGE_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  job_e                         job_kind_i,
  output logic                         pop_o,
  input  logic [255:0]                 key_i,
  input  logic [CHALLENGE_BYTES*8-1:0] chal_i,
  input  logic [RESPONSE_BYTES*8-1:0]  resp_i,
  output buf_ctrl_t                    ctrl_o,
  hcv_out_if.source                    out_o
);

  localparam int CW = CHALLENGE_BYTES * 8;
  localparam int LEN_IN_I = 64 + CHALLENGE_BYTES;
  localparam int TOT_IN_I = ((LEN_IN_I + 9 + 63) / 64) * 64;
  localparam logic [7:0] LEN_IN  = 8'(LEN_IN_I);
  localparam logic [7:0] TOT_IN  = 8'(TOT_IN_I);
  localparam logic [7:0] LEN_OUT = 8'd96;
  localparam logic [7:0] TOT_OUT = 8'd128;

  back_state_e state_q, state_d;
  logic        outer_q, outer_d;
  logic [7:0]  pos_q, pos_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [511:0] w_q, w_d;
  logic [255:0] v_q, v_d;
  logic [255:0] h_q, h_d;
  logic [255:0] kw_q, kw_d;
  logic [255:0] dig_q, dig_d;
  logic [CW-1:0] stored_q, stored_d;
  logic        stored_valid_q, stored_valid_d;
  verdict_e    verdict_q, verdict_d;
  logic [31:0] attempts_q, attempts_d, accepted_q, accepted_d;
  logic [31:0] replay_q, replay_d, mac_fail_q, mac_fail_d;
  logic        out_valid_q, out_valid_d;
  verdict_e    out_verdict_q, out_verdict_d;
  logic [31:0] out_att_q, out_att_d, out_acc_q, out_acc_d;
  logic [31:0] out_rep_q, out_rep_d, out_mac_q, out_mac_d;

  logic [7:0]  msg_len, msg_tot, msg_byte;
  logic        out_free;

  assign msg_len  = outer_q ? LEN_OUT : LEN_IN;
  assign msg_tot  = outer_q ? TOT_OUT : TOT_IN;
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_verdict_q;
  assign out_o.attempts_count = out_att_q;
  assign out_o.accepted_count = out_acc_q;
  assign out_o.replay_count   = out_rep_q;
  assign out_o.mac_fail_count = out_mac_q;

  // padded message stream, one byte per load cycle
  always_comb begin
    if (pos_q < 8'd64) begin
      msg_byte = kw_q[255:248] ^ (outer_q ? OPAD : IPAD);
    end else if (pos_q < msg_len) begin
      msg_byte = outer_q ? dig_q[255:248] : chal_i[CW-1 -: 8];
    end else if (pos_q == msg_len) begin
      msg_byte = PAD_START;
    end else if (pos_q == msg_tot - 8'd1) begin
      msg_byte = {msg_len[4:0], 3'b000};
    end else if (pos_q == msg_tot - 8'd2) begin
      msg_byte = {5'b00000, msg_len[7:5]};
    end else begin
      msg_byte = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_kind_i == JOB_MALFORMED) ? ST_EMIT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stored_valid_q && stored_q == chal_i) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_q == 6'd63) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (cnt_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (pos_q != msg_tot || !outer_q) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, wn;
    logic [255:0] h_sum;
    a  = v_q[255:224]; b = v_q[223:192]; c = v_q[191:160]; d = v_q[159:128];
    e  = v_q[127:96];  f = v_q[95:64];   g = v_q[63:32];   h = v_q[31:0];
    w0 = w_q[511:480];
    t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + sha_k(cnt_q) + w0;
    t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
    wn = ssig1(w_q[63:32]) + w_q[223:192] + ssig0(w_q[479:448]) + w0;
    for (int i = 0; i < 8; i++) begin
      h_sum[255-32*i -: 32] = h_q[255-32*i -: 32] + v_q[255-32*i -: 32];
    end

    outer_d        = outer_q;
    pos_d          = pos_q;
    cnt_d          = cnt_q;
    w_d            = w_q;
    v_d            = v_q;
    h_d            = h_q;
    kw_d           = kw_q;
    dig_d          = dig_q;
    stored_d       = stored_q;
    stored_valid_d = stored_valid_q;
    verdict_d      = verdict_q;
    attempts_d     = attempts_q;
    accepted_d     = accepted_q;
    replay_d       = replay_q;
    mac_fail_d     = mac_fail_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_verdict_d  = out_verdict_q;
    out_att_d      = out_att_q;
    out_acc_d      = out_acc_q;
    out_rep_d      = out_rep_q;
    out_mac_d      = out_mac_q;
    pop_o          = 1'b0;
    ctrl_o         = '0;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o     = 1'b1;
          verdict_d = VERDICT_MALFORMED;
        end
      end
      ST_CHECK: begin
        attempts_d = attempts_q + 32'd1;
        if (stored_valid_q && stored_q == chal_i) begin
          replay_d  = replay_q + 32'd1;
          verdict_d = VERDICT_REPLAY;
        end else begin
          outer_d = 1'b0;
          h_d     = SHA_IV;
          kw_d    = key_i;
          pos_d   = 8'd0;
          cnt_d   = 6'd0;
        end
      end
      ST_LOAD: begin
        w_d   = {w_q[503:0], msg_byte};
        pos_d = pos_q + 8'd1;
        cnt_d = cnt_q + 6'd1;
        if (pos_q < 8'd64) begin
          kw_d = {kw_q[247:0], 8'h00};
        end else if (pos_q < msg_len) begin
          if (outer_q) begin
            dig_d = {dig_q[247:0], 8'h00};
          end else begin
            ctrl_o.rotate_chal = 1'b1;
          end
        end
        if (cnt_q == 6'd63) begin
          v_d = h_q;
        end
      end
      ST_ROUND: begin
        v_d   = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_d   = {w_q[479:0], wn};
        cnt_d = cnt_q + 6'd1;
      end
      ST_ADD: begin
        h_d = h_sum;
        if (pos_q == msg_tot && !outer_q) begin
          // inner digest done, start the outer hash
          dig_d   = h_sum;
          outer_d = 1'b1;
          h_d     = SHA_IV;
          kw_d    = key_i;
          pos_d   = 8'd0;
        end
      end
      ST_MAC: begin
        if (h_q == resp_i) begin
          stored_d       = chal_i;
          stored_valid_d = 1'b1;
          accepted_d     = accepted_q + 32'd1;
          verdict_d      = VERDICT_ACCEPTED;
        end else begin
          mac_fail_d = mac_fail_q + 32'd1;
          verdict_d  = VERDICT_MAC_FAIL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          out_att_d     = attempts_q;
          out_acc_d     = accepted_q;
          out_rep_d     = replay_q;
          out_mac_d     = mac_fail_q;
          ctrl_o.release_lock = (verdict_q != VERDICT_MALFORMED);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      stored_valid_q <= 1'b0;
      attempts_q     <= '0;
      accepted_q     <= '0;
      replay_q       <= '0;
      mac_fail_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      stored_valid_q <= stored_valid_d;
      attempts_q     <= attempts_d;
      accepted_q     <= accepted_d;
      replay_q       <= replay_d;
      mac_fail_q     <= mac_fail_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    outer_q       <= outer_d;
    pos_q         <= pos_d;
    cnt_q         <= cnt_d;
    w_q           <= w_d;
    v_q           <= v_d;
    h_q           <= h_d;
    kw_q          <= kw_d;
    dig_q         <= dig_d;
    stored_q      <= stored_d;
    verdict_q     <= verdict_d;
    out_verdict_q <= out_verdict_d;
    out_att_q     <= out_att_d;
    out_acc_q     <= out_acc_d;
    out_rep_q     <= out_rep_d;
    out_mac_q     <= out_mac_d;
  end

endmodule

// File: design/hcv_checker.sv
`include "hmac_challenge_verifier_defines.svh"

module hcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [31:0] attempts_count,
  input logic [31:0] accepted_count,
  input logic [31:0] replay_count,
  input logic [31:0] mac_fail_count
);

  // every attempt ends in exactly one of the three tallied outcomes
  `HCV_ASSERT(a_tally_sum,
    out_valid |-> attempts_count == 32'(accepted_count + replay_count + mac_fail_count))

  `HCV_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(attempts_count))

  `HCV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid)

endmodule

bind hmac_challenge_verifier hcv_checker u_hcv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .verdict        (out_o.verdict),
  .attempts_count (out_o.attempts_count),
  .accepted_count (out_o.accepted_count),
  .replay_count   (out_o.replay_count),
  .mac_fail_count (out_o.mac_fail_count)
);

// File: sim/hmac_challenge_verifier_tb.sv
module hmac_challenge_verifier_tb import hcv_pkg::*; ;

  typedef logic [7:0] msg_t [128];

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       lst;
  } byte_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] attempts;
    logic [31:0] accepted;
    logic [31:0] replays;
    logic [31:0] mac_fails;
  } tally_t;

  localparam logic [2047:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [255:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int NBYTES = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;

  hcv_in_if  in_bus ();
  hcv_out_if out_bus ();

  hmac_challenge_verifier DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // key copy shared by the stimulus and the verdict predictor
  logic [63:0]  key_w [4];
  // predictor state
  logic [255:0] chal_buf, resp_buf, last_ok_chal;
  logic         last_ok_valid;
  int           chal_fill, resp_fill;
  logic [31:0]  n_attempts, n_accepted, n_replays, n_mac_fails;

  byte_item_t pending_q [$];
  tally_t     verdict_q [$];
  byte_item_t cur_item;
  int         in_gap, out_gap, errors, sent_cnt, gen_cnt;
  bit         idle_on, hold_off;
  // stimulus-side guess of the stored challenge, for building replays
  logic [255:0] gen_last_chal;
  bit           gen_have_chal;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha256_digest(input msg_t m, input int len);
    logic [7:0]  blk [128];
    logic [31:0] h [8];
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] s0, s1, t1, t2;
    logic [63:0] bits;
    logic [255:0] dig;
    int total, i, t, b;
    for (i = 0; i < 128; i++) blk[i] = (i < len) ? m[i] : 8'h00;
    blk[len] = 8'h80;
    total = ((len + 72) / 64) * 64;
    bits = 64'(len) * 8;
    for (i = 0; i < 8; i++) blk[total - 1 - i] = bits[8*i +: 8];
    for (i = 0; i < 8; i++) h[i] = HASH_INIT[255 - 32*i -: 32];
    for (b = 0; b < total; b += 64) begin
      for (t = 0; t < 16; t++)
        w[t] = {blk[b+4*t], blk[b+4*t+1], blk[b+4*t+2], blk[b+4*t+3]};
      for (t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (i = 0; i < 8; i++) v[i] = h[i];
      for (t = 0; t < 64; t++) begin
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[2047 - 32*t -: 32] + w[t];
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (i = 7; i > 0; i--) v[i] = v[i-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) h[i] = h[i] + v[i];
    end
    for (i = 0; i < 8; i++) dig[255 - 32*i -: 32] = h[i];
    return dig;
  endfunction

  function automatic logic [255:0] hmac_of(input logic [255:0] chal);
    msg_t m;
    logic [255:0] inner;
    logic [7:0] kb;
    int i;
    for (i = 0; i < 128; i++) m[i] = 8'h00;
    for (i = 0; i < 64; i++) begin
      kb = (i < 32) ? key_w[i/8][63 - 8*(i%8) -: 8] : 8'h00;
      m[i] = kb ^ 8'h36;
    end
    for (i = 0; i < 32; i++) m[64+i] = chal[255 - 8*i -: 8];
    inner = sha256_digest(m, 96);
    for (i = 0; i < 64; i++) begin
      kb = (i < 32) ? key_w[i/8][63 - 8*(i%8) -: 8] : 8'h00;
      m[i] = kb ^ 8'h5c;
    end
    for (i = 0; i < 32; i++) m[64+i] = inner[255 - 8*i -: 8];
    return sha256_digest(m, 96);
  endfunction

  function automatic void push_verdict(input verdict_e vd);
    tally_t e;
    e.verdict   = vd;
    e.attempts  = n_attempts;
    e.accepted  = n_accepted;
    e.replays   = n_replays;
    e.mac_fails = n_mac_fails;
    verdict_q.push_back(e);
    chal_fill = 0;
    resp_fill = 0;
  endfunction

  function automatic void predict_byte(input byte_item_t it);
    if (it.op == OP_CHALLENGE) begin
      if (it.lst || resp_fill != 0 || chal_fill >= NBYTES) begin
        push_verdict(VERDICT_MALFORMED);
      end else begin
        chal_buf[255 - 8*chal_fill -: 8] = it.data;
        chal_fill++;
      end
    end else if (chal_fill != NBYTES || resp_fill >= RESPONSE_BYTES) begin
      push_verdict(VERDICT_MALFORMED);
    end else begin
      resp_buf[255 - 8*resp_fill -: 8] = it.data;
      resp_fill++;
      if (it.lst) begin
        if (resp_fill != RESPONSE_BYTES) begin
          push_verdict(VERDICT_MALFORMED);
        end else begin
          n_attempts++;
          if (last_ok_valid && chal_buf == last_ok_chal) begin
            n_replays++;
            push_verdict(VERDICT_REPLAY);
          end else if (hmac_of(chal_buf) != resp_buf) begin
            n_mac_fails++;
            push_verdict(VERDICT_MAC_FAIL);
          end else begin
            last_ok_chal  = chal_buf;
            last_ok_valid = 1'b1;
            n_accepted++;
            push_verdict(VERDICT_ACCEPTED);
          end
        end
      end
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_byte(cur_item);
        sent_cnt++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 5) - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.operation <= cur_item.op;
          in_bus.data_byte <= cur_item.data;
          in_bus.last_byte <= cur_item.lst;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    tally_t e;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict %0d", out_bus.verdict);
        end else begin
          e = verdict_q.pop_front();
          if (e.verdict !== out_bus.verdict || e.attempts !== out_bus.attempts_count ||
              e.accepted !== out_bus.accepted_count || e.replays !== out_bus.replay_count ||
              e.mac_fails !== out_bus.mac_fail_count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.verdict, e.attempts, e.accepted, e.replays, e.mac_fails,
                       out_bus.verdict, out_bus.attempts_count, out_bus.accepted_count,
                       out_bus.replay_count, out_bus.mac_fail_count);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 5) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !hold_off;
      end
    end
  end

  // long receiver hold-off so the job queue fills and the input backs up
  initial begin
    hold_off = 1'b0;
    wait (sent_cnt >= 450);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_item(input logic op, input logic [7:0] d, input logic lst);
    byte_item_t it;
    it.op = op;
    it.data = d;
    it.lst = lst;
    pending_q.push_back(it);
    gen_cnt++;
  endtask

  task automatic push_chal(input logic [255:0] c, input int n);
    for (int i = 0; i < n; i++) push_item(OP_CHALLENGE, c[255 - 8*i -: 8], 1'b0);
  endtask

  task automatic push_resp(input logic [255:0] r, input int n, input bit mark_last);
    for (int i = 0; i < n; i++)
      push_item(OP_RESPONSE, r[255 - 8*i -: 8], mark_last && (i == n - 1));
  endtask

  function automatic logic [255:0] rand256();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
    return r;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_bus.valid || verdict_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_key(input int idx, input logic [63:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_KEY_WORD_0 + 3'(idx);
    cfg_data <= v;
    key_w[idx] = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic gen_sequences(input int upto);
    logic [255:0] c, r;
    int kind, k;
    while (gen_cnt < upto) begin
      kind = $urandom_range(0, 9);
      c = rand256();
      if (kind == 4 && gen_have_chal) c = gen_last_chal;
      r = hmac_of(c);
      case (kind)
        0, 1, 2, 3, 4: begin
          push_chal(c, NBYTES);
          push_resp(r, RESPONSE_BYTES, 1'b1);
          gen_last_chal = c;
          gen_have_chal = 1'b1;
        end
        5, 6: begin
          if ($urandom_range(0, 1)) r = rand256();
          else r[8*$urandom_range(0, 31) +: 8] ^= 8'($urandom_range(1, 255));
          push_chal(c, NBYTES);
          push_resp(r, RESPONSE_BYTES, 1'b1);
        end
        7: begin
          k = $urandom_range(1, 31);
          case ($urandom_range(0, 4))
            0: begin  // one challenge byte too many
              push_chal(c, NBYTES);
              push_item(OP_CHALLENGE, 8'($urandom), 1'b0);
            end
            1: begin  // response short at last_byte
              push_chal(c, NBYTES);
              push_resp(r, k, 1'b1);
            end
            2: begin  // response runs past its length
              push_chal(c, NBYTES);
              push_resp(r, RESPONSE_BYTES, 1'b0);
              push_item(OP_RESPONSE, 8'($urandom), 1'($urandom));
            end
            3: begin  // challenge byte after response bytes
              push_chal(c, NBYTES);
              push_resp(r, k, 1'b0);
              push_item(OP_CHALLENGE, 8'($urandom), 1'($urandom));
            end
            default: begin  // response before challenge complete
              push_chal(c, k);
              push_item(OP_RESPONSE, 8'($urandom), 1'($urandom));
            end
          endcase
        end
        8: begin
          repeat ($urandom_range(1, 4))
            push_item(1'($urandom), 8'($urandom), 1'($urandom));
        end
        default: begin  // last_byte on a challenge byte mid-sequence
          push_chal(c, $urandom_range(0, 31));
          push_item(OP_CHALLENGE, 8'($urandom), 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_KEY_WORD_0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_CHALLENGE;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    out_bus.ready = 1'b0;
    idle_on = 1'b1;
    in_gap = 0; out_gap = 0; errors = 0; sent_cnt = 0; gen_cnt = 0;
    gen_have_chal = 1'b0;
    last_ok_valid = 1'b0;
    chal_fill = 0; resp_fill = 0;
    n_attempts = '0; n_accepted = '0; n_replays = '0; n_mac_fails = '0;
    chal_buf = '0; resp_buf = '0; last_ok_chal = '0;
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < 4; i++) write_key(i, '1);
    // directed: malformed shapes and extreme bytes, then an all-ones accept and its replay
    push_item(OP_RESPONSE, 8'hff, 1'b1);
    push_item(OP_CHALLENGE, 8'h00, 1'b1);
    push_item(OP_CHALLENGE, 8'hff, 1'b0);
    push_item(OP_RESPONSE, 8'h00, 1'b0);
    push_item(OP_CHALLENGE, 8'h00, 1'b0);
    push_item(OP_CHALLENGE, 8'hff, 1'b1);
    push_chal('1, NBYTES);
    push_resp(hmac_of('1), RESPONSE_BYTES, 1'b1);
    push_chal('1, NBYTES);
    push_resp(hmac_of('1), RESPONSE_BYTES, 1'b1);
    gen_last_chal = '1;
    gen_have_chal = 1'b1;
    gen_sequences(350);
    wait_idle();

    for (int i = 0; i < 4; i++) write_key(i, {$urandom, $urandom});
    gen_sequences(700);
    wait_idle();

    for (int i = 0; i < 4; i++) write_key(i, '0);
    push_chal('0, NBYTES);
    push_resp(hmac_of('0), RESPONSE_BYTES, 1'b1);
    gen_sequences(950);
    wait_idle();

    for (int i = 0; i < 4; i++) write_key(i, {$urandom, $urandom});
    idle_on = 1'b0;
    gen_sequences(1250);
    wait_idle();
    repeat (50) @(posedge clk_i);

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
